// File: rtl/dtq_pkg.sv
// dtq_pkg: shared types and codes for the double-ended task queue
// holds request actions, result status codes and per-cell load commands
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dtq_pkg;

   localparam int ACTION_W = 3;
   localparam int HANDLE_W = 16;
   localparam int KEY_W    = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH_BACK  = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_POP_BACK   = 3'd2,
      ACT_POP_FRONT  = 3'd3,
      ACT_REMOVE_KEY = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_NOKEY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_PREV,
      CELL_FROM_NEXT
   } cell_op_type;

endpackage

`default_nettype wire

// File: rtl/dtq_cell.sv
// dtq_cell: one queue slot holding a handle and a key
// loads a new entry or takes its neighbour's entry; compares its key with the probe
// depends on dtq_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtq_cell
   import dtq_pkg::*;
#(
   parameter int HANDLE_BITS = 16,
   parameter int KEY_BITS    = 32
) (
   input  wire logic                   clock,
   input  wire cell_op_type            op,
   input  wire logic [HANDLE_BITS-1:0] new_handle,
   input  wire logic [KEY_BITS-1:0]    new_key,
   input  wire logic [HANDLE_BITS-1:0] prev_handle,
   input  wire logic [KEY_BITS-1:0]    prev_key,
   input  wire logic [HANDLE_BITS-1:0] next_handle,
   input  wire logic [KEY_BITS-1:0]    next_key,
   input  wire logic [KEY_BITS-1:0]    probe_key,
   output logic      [HANDLE_BITS-1:0] handle,
   output logic      [KEY_BITS-1:0]    key,
   output logic      [HANDLE_BITS-1:0] handle_nx,
   output logic                        hit
);

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;

   always_comb begin
      case (op)
         CELL_LOAD: begin
            handle_in = new_handle;
            key_in    = new_key;
         end
         CELL_FROM_PREV: begin
            handle_in = prev_handle;
            key_in    = prev_key;
         end
         CELL_FROM_NEXT: begin
            handle_in = next_handle;
            key_in    = next_key;
         end
         default: begin
            handle_in = handle_ff;
            key_in    = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      key_ff    <= key_in;
   end

   assign handle    = handle_ff;
   assign key       = key_ff;
   assign handle_nx = handle_in;
   assign hit       = (key_ff == probe_key);

endmodule

`default_nettype wire

// File: rtl/double_ended_task_queue.sv
// double_ended_task_queue: bounded deque of task entries with keyed removal
// a row of dtq_cell slots with the decode, match priority and result register
// depends on dtq_pkg and dtq_cell
//
// Each request's result word is loaded into the result register in the cycle
// after the request is taken; a new request is taken in every cycle in which the
// result register is empty or its word is being taken, so the queue runs at
// one request per clock. Slot 0 of the cell row is the front. Every cell compares
// its key with the request key in the same cycle and the nearest match to the
// front is removed, the cells behind it each taking their neighbour's entry.
// Pushes at the front shift the row the other way. No clearing pass is needed
// after reset: only the entry count and the result valid flag are cleared.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_task_queue
   import dtq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16,
   parameter int HANDLE_BITS = 16,
   parameter int KEY_BITS    = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // action [2:0], task_handle [18:3], task_key [50:19], zero [55:51]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status [1:0], removed_handle [17:2], front_handle [33:18],
   // back_handle [49:34], is_empty [50], entry_count [55:51]
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int IW = $clog2(QUEUE_DEPTH);

   logic [ACTION_W-1:0]    req_action;
   logic [HANDLE_BITS-1:0] req_handle;
   logic [KEY_BITS-1:0]    req_key;
   logic                   req_fire;

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   cell_op_type            cell_op     [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_handle [QUEUE_DEPTH];
   logic [KEY_BITS-1:0]    cell_key    [QUEUE_DEPTH];
   logic [HANDLE_BITS-1:0] cell_nx     [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_hit;
   logic [QUEUE_DEPTH-1:0] occupied;
   logic [QUEUE_DEPTH-1:0] hit_vec;
   logic [QUEUE_DEPTH-1:0] first_hit;
   logic [QUEUE_DEPTH-1:0] shift_up;

   status_type             status;
   logic [HANDLE_BITS-1:0] removed;
   logic [HANDLE_BITS-1:0] match_handle;
   logic [HANDLE_BITS-1:0] front_nx;
   logic [HANDLE_BITS-1:0] back_nx;
   logic                   full;
   logic                   empty;

   assign req_action = req_tdata[2:0];
   assign req_handle = HANDLE_BITS'(req_tdata[18:3]);
   assign req_key    = KEY_BITS'(req_tdata[50:19]);

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   genvar g;
   generate
      for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
         dtq_cell #(
            .HANDLE_BITS(HANDLE_BITS),
            .KEY_BITS   (KEY_BITS)
         ) u_cell (
            .clock      (clock),
            .op         (cell_op[g]),
            .new_handle (req_handle),
            .new_key    (req_key),
            .prev_handle(cell_handle[(g == 0) ? 0 : g - 1]),
            .prev_key   (cell_key[(g == 0) ? 0 : g - 1]),
            .next_handle(cell_handle[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .next_key   (cell_key[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
            .probe_key  (req_key),
            .handle     (cell_handle[g]),
            .key        (cell_key[g]),
            .handle_nx  (cell_nx[g]),
            .hit        (cell_hit[g])
         );
         assign occupied[g] = (CW'(g) < count_ff);
      end
   endgenerate

   assign hit_vec = cell_hit & occupied;
   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);

   // nearest match to the front, and every slot from it backwards
   always_comb begin
      logic [QUEUE_DEPTH-1:0] below;
      match_handle = '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         below        = ~({QUEUE_DEPTH{1'b1}} << i);
         first_hit[i] = hit_vec[i] && !(|(hit_vec & below));
         shift_up[i]  = hit_vec[i] || (|(hit_vec & below));
         match_handle = match_handle | (first_hit[i] ? cell_handle[i] : '0);
      end
   end

   always_comb begin
      status   = ST_OK;
      removed  = '0;
      count_in = count_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         cell_op[i] = CELL_HOLD;
      end
      case (req_action)
         ACT_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  if (CW'(i) == count_ff) begin
                     cell_op[i] = CELL_LOAD;
                  end
               end
            end
         end
         ACT_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               count_in = count_ff + CW'(1);
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  cell_op[i] = (i == 0) ? CELL_LOAD : CELL_FROM_PREV;
               end
            end
         end
         ACT_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               removed  = cell_handle[IW'(count_ff - CW'(1))];
            end
         end
         ACT_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
               removed  = cell_handle[0];
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  cell_op[i] = CELL_FROM_NEXT;
               end
            end
         end
         ACT_REMOVE_KEY: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (!(|hit_vec)) begin
               status = ST_NOKEY;
            end else begin
               count_in = count_ff - CW'(1);
               removed  = match_handle;
               for (int i = 0; i < QUEUE_DEPTH; i++) begin
                  cell_op[i] = shift_up[i] ? CELL_FROM_NEXT : CELL_HOLD;
               end
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      if (!req_fire) begin
         count_in = count_ff;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            cell_op[i] = CELL_HOLD;
         end
      end
   end

   assign front_nx = (count_in != '0) ? cell_nx[0] : '0;
   assign back_nx  = (count_in != '0) ? cell_nx[IW'(count_in - CW'(1))] : '0;

   always_comb begin
      rsp_data_in = {
         COUNT_W'(count_in),
         (count_in == '0),
         HANDLE_W'(back_nx),
         HANDLE_W'(front_nx),
         HANDLE_W'(removed),
         status
      };
      rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// testbench: self-checking bench for double_ended_task_queue on its request and result streams
// a scoreboard class keeps its own deque of handles and keys and checks every result word
// depends on dtq_pkg and double_ended_task_queue
`timescale 1ns / 1ps

module testbench;
   import dtq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_RUN  = 1750;
   localparam int PHASE_LEN   = 50;
   localparam int LONG_HOLD   = 80;
   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [1:0]  status;
      logic [15:0] removed;
      logic [15:0] front;
      logic [15:0] back;
      logic        empty;
      logic [4:0]  count;
   } queue_snapshot;

   class task_queue_scoreboard;
      logic [15:0]   held_handles[$];
      logic [31:0]   held_keys[$];
      queue_snapshot expected_snapshots[$];
      int            mismatches;
      int            results_checked;
      int            status_seen[4];

      function void note_request(logic [2:0] action, logic [15:0] handle, logic [31:0] key);
         queue_snapshot s;
         int            hit;
         s.status  = ST_OK;
         s.removed = '0;
         hit       = -1;
         case (action)
            ACT_PUSH_BACK: begin
               if (held_handles.size() >= DEPTH) begin
                  s.status = ST_FULL;
               end else begin
                  held_handles.push_back(handle);
                  held_keys.push_back(key);
               end
            end
            ACT_PUSH_FRONT: begin
               if (held_handles.size() >= DEPTH) begin
                  s.status = ST_FULL;
               end else begin
                  held_handles.push_front(handle);
                  held_keys.push_front(key);
               end
            end
            ACT_POP_BACK: begin
               if (held_handles.size() == 0) begin
                  s.status = ST_EMPTY;
               end else begin
                  s.removed = held_handles.pop_back();
                  void'(held_keys.pop_back());
               end
            end
            ACT_POP_FRONT: begin
               if (held_handles.size() == 0) begin
                  s.status = ST_EMPTY;
               end else begin
                  s.removed = held_handles.pop_front();
                  void'(held_keys.pop_front());
               end
            end
            ACT_REMOVE_KEY: begin
               if (held_handles.size() == 0) begin
                  s.status = ST_EMPTY;
               end else begin
                  s.status = ST_NOKEY;
                  for (int i = 0; i < held_keys.size(); i++) begin
                     if (hit < 0 && held_keys[i] == key) hit = i;
                  end
                  // nearest match to the front leaves, the rest close up
                  if (hit >= 0) begin
                     s.status  = ST_OK;
                     s.removed = held_handles[hit];
                     held_handles.delete(hit);
                     held_keys.delete(hit);
                  end
               end
            end
            default: ;
         endcase
         s.front = (held_handles.size() > 0) ? held_handles[0] : '0;
         s.back  = (held_handles.size() > 0) ? held_handles[held_handles.size() - 1] : '0;
         s.empty = (held_handles.size() == 0);
         s.count = 5'(held_handles.size());
         status_seen[s.status]++;
         expected_snapshots.push_back(s);
      endfunction

      task report_mismatch(string what, logic [55:0] want, logic [55:0] got);
         $display("mismatch at result %0d: %s expected %0h got %0h",
                  results_checked, what, want, got);
         mismatches++;
      endtask

      task check_result(logic [55:0] word);
         queue_snapshot want;
         queue_snapshot got;
         got.status  = word[1:0];
         got.removed = word[17:2];
         got.front   = word[33:18];
         got.back    = word[49:34];
         got.empty   = word[50];
         got.count   = word[55:51];
         if (expected_snapshots.size() == 0) begin
            report_mismatch("word with no request outstanding", '0, word);
         end else begin
            want = expected_snapshots.pop_front();
            if (got.status !== want.status)
               report_mismatch("status", 56'(want.status), 56'(got.status));
            if (got.removed !== want.removed)
               report_mismatch("removed_handle", 56'(want.removed), 56'(got.removed));
            if (got.front !== want.front)
               report_mismatch("front_handle", 56'(want.front), 56'(got.front));
            if (got.back !== want.back)
               report_mismatch("back_handle", 56'(want.back), 56'(got.back));
            if (got.empty !== want.empty)
               report_mismatch("is_empty", 56'(want.empty), 56'(got.empty));
            if (got.count !== want.count)
               report_mismatch("entry_count", 56'(want.count), 56'(got.count));
         end
         results_checked++;
      endtask

      function int pending_results();
         return expected_snapshots.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;

   task_queue_scoreboard sb = new();

   bit idling_on;
   int sender_idle_pct;
   int rx_idle_pct;
   bit hold_request;
   int hold_left;
   int quiet_cycles;
   int requests_sent;

   double_ended_task_queue i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: random stall bursts, or one long hold on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            rsp_tready   <= 1'b0;
         end else if (idling_on && $urandom_range(0, 99) < rx_idle_pct) begin
            hold_left  = $urandom_range(1, 10) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("no word moved for %0d cycles", STALL_LIMIT);
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic send_request(logic [2:0] action, logic [15:0] handle, logic [31:0] key);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b0, key, handle, action};
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, handle, key);
      requests_sent++;
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tdata  <= {5'b0, 51'($urandom()) ^ {19'($urandom()), 32'h0}};
      repeat (cycles - 1) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_key();
      case ($urandom_range(0, 4))
         0, 1: return $urandom_range(0, 7);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h0000_0000;
               1: return 32'hffff_ffff;
               2: return 32'h8000_0000;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [15:0] pick_handle();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_random(int push_pct);
      int          r;
      int          n;
      logic [2:0]  action;
      logic [31:0] key;
      r   = $urandom_range(0, 99);
      key = pick_key();
      if (r < push_pct) begin
         action = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
      end else if (r < 97) begin
         case ($urandom_range(0, 4))
            0: action = ACT_POP_BACK;
            1: action = ACT_POP_FRONT;
            default: action = ACT_REMOVE_KEY;
         endcase
         n = sb.held_keys.size();
         if (action == ACT_REMOVE_KEY && n > 0 && $urandom_range(0, 9) < 7)
            key = sb.held_keys[$urandom_range(0, n - 1)];
      end else begin
         action = 3'($urandom_range(5, 7));
      end
      send_request(action, pick_handle(), key);
      if (idling_on && $urandom_range(0, 99) < sender_idle_pct) idle_gap($urandom_range(1, 10));
   endtask

   initial begin
      int phase;
      idling_on       = 1'b0;
      sender_idle_pct = 0;
      rx_idle_pct     = 0;
      hold_request    = 1'b0;
      hold_left       = 0;
      quiet_cycles    = 0;
      requests_sent   = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty queue cases and unused codes
      send_request(ACT_POP_BACK, 16'h1234, 32'h0);
      send_request(ACT_POP_FRONT, 16'h1234, 32'h0);
      send_request(ACT_REMOVE_KEY, 16'h0, 32'h0);
      send_request(3'd5, 16'hffff, 32'hffff_ffff);
      send_request(3'd6, 16'h0, 32'h0);
      send_request(3'd7, 16'hffff, 32'hffff_ffff);
      // extremes and duplicate keys
      send_request(ACT_PUSH_BACK, 16'h0000, 32'h0000_0000);
      send_request(ACT_PUSH_FRONT, 16'hffff, 32'hffff_ffff);
      send_request(ACT_PUSH_BACK, 16'h5555, 32'hffff_ffff);
      send_request(ACT_REMOVE_KEY, 16'h0, 32'h1234_5678);
      send_request(ACT_REMOVE_KEY, 16'h0, 32'hffff_ffff);
      send_request(ACT_PUSH_FRONT, 16'haaaa, 32'h0000_0000);
      send_request(ACT_REMOVE_KEY, 16'hffff, 32'h0000_0000);
      send_request(ACT_PUSH_BACK, 16'h8000, 32'h8000_0000);
      send_request(ACT_PUSH_BACK, 16'h0001, 32'h0000_0001);
      // removal from the middle
      send_request(ACT_REMOVE_KEY, 16'h0, 32'h8000_0000);
      send_request(ACT_POP_BACK, 16'h0, 32'h0);
      send_request(ACT_POP_FRONT, 16'h0, 32'h0);
      send_request(ACT_POP_FRONT, 16'h0, 32'h0);
      send_request(ACT_POP_BACK, 16'h0, 32'h0);
      send_request(ACT_PUSH_BACK, 16'h7fff, 32'h7fff_ffff);
      send_request(ACT_POP_BACK, 16'h0, 32'h0);

      for (phase = 0; phase < RANDOM_RUN / PHASE_LEN; phase++) begin
         idling_on       = (phase < RANDOM_RUN / PHASE_LEN - 5);
         sender_idle_pct = (phase % 4 == 3) ? 0 : 5 + 10 * (phase % 3);
         rx_idle_pct     = (phase % 4 == 1) ? 0 : 4 + 8 * (phase % 3);
         if (phase == 10) begin
            // long result stall that holds back the requests behind it, then pushes that run the queue into full
            hold_request = 1'b1;
            repeat (24) send_request($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
                                     pick_handle(), pick_key());
         end
         if (phase == 20) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (sb.pending_results() != 0) @(posedge clock);
         end
         repeat (PHASE_LEN)
            send_random((phase % 3 == 0) ? 80 : (phase % 3 == 1) ? 25 : 55);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_results() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests sent, %0d result words checked", requests_sent,
               sb.results_checked);
      $display("status ok %0d, empty %0d, full %0d, key not found %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
               sb.status_seen[ST_FULL], sb.status_seen[ST_NOKEY]);
      if (sb.mismatches == 0 && sb.pending_results() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
